// ===== hw/rtl/spfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_pkg
// Types and constants shared by the single-precision adder pipeline.
// ----------------------------------------------------------------------------
package spfa_pkg;

	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] QUIET_NAN  = 32'h7fc0_0000;
	localparam logic [31:0] POS_INF    = 32'h7f80_0000;
	localparam logic [23:0] HIDDEN_ONE = 24'h80_0000;
	localparam logic [22:0] FRAC_MASK  = 23'h7f_ffff;
	localparam int          EXP_BIAS   = 127;

	// operation select
	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} op_t;

	// aligned operands, handed from align to add
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        sa;
		logic        sb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [8:0]  er;
	} align_t;

	// raw magnitude result, handed from add to normalize
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic        sr;
		logic [24:0] mr;
		logic [8:0]  er;
	} sum_t;

	// round to nearest even on a right shift of a 24-bit significand
	function automatic logic [24:0] rne_shift(input logic [23:0] v, input logic [8:0] d);
		logic [23:0] lost;
		logic [23:0] half;
		logic [24:0] q;
		lost = '0;
		half = '0;
		q = {1'b0, v};
		if (d == 9'd0) begin
			q = {1'b0, v};
		end else if (d > 9'd24) begin
			q = '0;
		end else begin
			lost = v & ((24'd1 << d[4:0]) - 24'd1);
			half = 24'd1 << (d[4:0] - 5'd1);
			q = {1'b0, v >> d[4:0]};
			if (lost > half) begin
				q = q + 25'd1;
			end else if (lost == half) begin
				q = q + {24'd0, q[0]};
			end
		end
		return q;
	endfunction

endpackage

// ===== hw/rtl/single_precision_float_adder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_precision_float_adder
// IEEE-754 single-precision add/subtract, three-stage pipeline.
// ----------------------------------------------------------------------------
// A new word can be taken every cycle while in_stall is low. The work sits in
// three register stages (align, add, normalize), and each word passes through
// them in that order before its sum shows on the output.
// An output stall holds the last stage; earlier stages still move into
// empty slots, so the input stalls only when all three stages hold a word and
// the output is stalled.
module single_precision_float_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] left_operand,
	input  logic [31:0] right_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_bits
);

	spfa_pkg::align_t aligned;
	spfa_pkg::align_t align_s1;
	spfa_pkg::sum_t   summed;
	spfa_pkg::sum_t   sum_s2;
	logic [31:0]      result;
	logic [31:0]      res_s3;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             en3;
	logic             en2;
	logic             en1;

	spfa_align u_align (
		.operation     (operation),
		.left_operand  (left_operand),
		.right_operand (right_operand),
		.aligned       (aligned)
	);

	spfa_addsub u_addsub (
		.aligned (align_s1),
		.summed  (summed)
	);

	spfa_norm u_norm (
		.summed (sum_s2),
		.result (result)
	);

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s3;
	assign sum_bits = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) align_s1 <= aligned;
		if (en2) sum_s2 <= summed;
		if (en3) res_s3 <= result;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && out_stall |=> v_s3 && $stable(res_s3))
		else $error("result changed under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_stall |=> v_s3)
		else $error("stage two word lost");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && out_stall)
		else $error("stall without full pipeline");

endmodule

// ===== hw/rtl/spfa_align.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_align
// Stage one: screens specials, unpacks and aligns the smaller significand.
// ----------------------------------------------------------------------------
module spfa_align (
	input  logic                  operation,
	input  logic [31:0]           left_operand,
	input  logic [31:0]           right_operand,
	output spfa_pkg::align_t      aligned
);

	logic [31:0] a;
	logic [31:0] b;
	logic [7:0]  ea_raw;
	logic [7:0]  eb_raw;
	logic [23:0] ma;
	logic [23:0] mb;
	logic [24:0] sh;

	assign a = left_operand;
	assign b = (operation == spfa_pkg::OP_SUB) ? (right_operand ^ spfa_pkg::SIGN_BIT) :
		right_operand;
	assign ea_raw = a[30:23];
	assign eb_raw = b[30:23];
	assign ma = (a[30:0] == 31'd0) ? 24'd0 : (spfa_pkg::HIDDEN_ONE | {1'b0, a[22:0]});
	assign mb = (b[30:0] == 31'd0) ? 24'd0 : (spfa_pkg::HIDDEN_ONE | {1'b0, b[22:0]});

	always_comb begin
		aligned = '0;
		aligned.sa = a[31];
		aligned.sb = b[31];
		aligned.ma = ma;
		aligned.mb = mb;
		aligned.special = 1'b0;
		aligned.special_bits = b;
		sh = '0;
		if (ea_raw == 8'hff) begin
			aligned.special = 1'b1;
			if (a[22:0] != 23'd0) begin
				aligned.special_bits = a;
			end else if (eb_raw == 8'hff) begin
				if (b[22:0] != 23'd0) begin
					aligned.special_bits = b;
				end else begin
					aligned.special_bits = (a[31] == b[31]) ? b : spfa_pkg::QUIET_NAN;
				end
			end else begin
				aligned.special_bits = a;
			end
		end else if (eb_raw == 8'hff) begin
			aligned.special = 1'b1;
		end
		// larger exponent kept in biased form (raw field)
		aligned.er = {1'b0, eb_raw};
		if (eb_raw > ea_raw) begin
			sh = spfa_pkg::rne_shift(ma, {1'b0, eb_raw - ea_raw});
			aligned.ma = sh[23:0];
		end else if (eb_raw < ea_raw) begin
			sh = spfa_pkg::rne_shift(mb, {1'b0, ea_raw - eb_raw});
			aligned.mb = sh[23:0];
			aligned.er = {1'b0, ea_raw};
		end
	end

endmodule

// ===== hw/rtl/spfa_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_addsub
// Stage two: adds or subtracts the aligned magnitudes.
// ----------------------------------------------------------------------------
module spfa_addsub (
	input  spfa_pkg::align_t aligned,
	output spfa_pkg::sum_t   summed
);

	always_comb begin
		summed.special = aligned.special;
		summed.special_bits = aligned.special_bits;
		summed.er = aligned.er;
		if (aligned.sa != aligned.sb) begin
			if (aligned.ma > aligned.mb) begin
				summed.mr = {1'b0, aligned.ma - aligned.mb};
				summed.sr = aligned.sa;
			end else begin
				summed.mr = {1'b0, aligned.mb - aligned.ma};
				summed.sr = aligned.sb;
			end
		end else begin
			summed.mr = {1'b0, aligned.ma} + {1'b0, aligned.mb};
			summed.sr = aligned.sa;
		end
	end

endmodule

// ===== hw/rtl/spfa_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spfa_norm
// Stage three: normalizes, handles carry-out, overflow and packs.
// ----------------------------------------------------------------------------
module spfa_norm (
	input  spfa_pkg::sum_t summed,
	output logic [31:0]    result
);

	logic [24:0] r;
	logic [24:0] m;
	logic [9:0]  e;
	logic [4:0]  lz;
	logic [9:0]  room;
	logic [4:0]  sh;

	// leading zero count of a 24-bit significand
	always_comb begin
		lz = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (summed.mr[i]) begin
				lz = 5'(23 - i);
			end
		end
	end

	always_comb begin
		r = '0;
		m = summed.mr;
		e = {1'b0, summed.er};
		room = '0;
		sh = '0;
		if (summed.mr[24]) begin
			// shift by one, ties to even on the dropped bit
			r = {1'b0, summed.mr[24:1]} + {24'd0, summed.mr[0] & summed.mr[1]};
			m = r;
			e = e + 10'd1;
			if (m[24]) begin
				m = m >> 1;
				e = e + 10'd1;
			end
		end else begin
			// biased exponent may not drop below zero
			room = e;
			sh = (room < {5'd0, lz}) ? room[4:0] : lz;
			m = summed.mr << sh;
			e = e - {5'd0, sh};
		end
		if (summed.special) begin
			result = summed.special_bits;
		end else if (summed.mr == 25'd0) begin
			result = 32'd0;
		end else if (e > 10'd254) begin
			result = {summed.sr, spfa_pkg::POS_INF[30:0]};
		end else begin
			result = {summed.sr, e[7:0], m[22:0] & spfa_pkg::FRAC_MASK};
		end
	end

endmodule

// ===== test/tb_single_precision_float_adder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_precision_float_adder
// Drives add/subtract words through the adder pipeline with random idling on
// both sides, predicts each sum in a local model, and compares every result.
// ----------------------------------------------------------------------------
module tb_single_precision_float_adder;

	typedef struct {
		spfa_pkg::op_t op;
		logic [31:0]   a;
		logic [31:0]   b;
		logic          known;
		logic [31:0]   sum;
	} vec_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] left_operand;
	logic [31:0] right_operand;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] sum_bits;

	logic [31:0] sum_queue[$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_rx;

	single_precision_float_adder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .left_operand(left_operand),
		.right_operand(right_operand),
		.out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] round_shift(logic [31:0] v, int unsigned d);
		logic [31:0] lost;
		logic [31:0] half;
		logic [31:0] q;
		if (d == 0) return v;
		if (d >= 32) return 32'd0;
		lost = v & ((32'd1 << d) - 32'd1);
		half = 32'd1 << (d - 1);
		q = v >> d;
		if (lost > half) q = q + 32'd1;
		else if (lost == half) q = q + {31'd0, q[0]};
		return q;
	endfunction

	function automatic logic [31:0] float_sum(spfa_pkg::op_t op, logic [31:0] a,
		logic [31:0] bin);
		logic [31:0] b;
		logic        sa, sb, sr;
		logic [7:0]  xa, xb;
		logic [22:0] fa, fb;
		int          ea, eb, er;
		logic [31:0] ma, mb, mr;
		b = (op == spfa_pkg::OP_SUB) ? (bin ^ spfa_pkg::SIGN_BIT) : bin;
		sa = a[31]; sb = b[31];
		xa = a[30:23]; xb = b[30:23];
		fa = a[22:0]; fb = b[22:0];
		if (xa == 8'hff) begin
			if (fa != 0) return a;
			if (xb == 8'hff) begin
				if (fb != 0) return b;
				return (sa == sb) ? b : spfa_pkg::QUIET_NAN;
			end
			return a;
		end
		if (xb == 8'hff) return b;
		ea = int'(xa) - spfa_pkg::EXP_BIAS;
		eb = int'(xb) - spfa_pkg::EXP_BIAS;
		ma = (a[30:0] == 0) ? 32'd0 : {9'd1, fa};
		mb = (b[30:0] == 0) ? 32'd0 : {9'd1, fb};
		er = eb;
		if (eb > ea) ma = round_shift(ma, eb - ea);
		else if (eb < ea) begin
			mb = round_shift(mb, ea - eb);
			er = ea;
		end
		if (sa != sb) begin
			if (ma > mb) begin mr = ma - mb; sr = sa; end
			else begin mr = mb - ma; sr = sb; end
		end else begin
			mr = ma + mb;
			sr = sa;
		end
		if (mr == 0) return 32'd0;
		if (mr >= 32'h100_0000) begin
			mr = round_shift(mr, 1);
			er++;
			if (mr >= 32'h100_0000) begin
				mr = mr >> 1;
				er++;
			end
		end else begin
			while (mr < 32'h80_0000 && er > -spfa_pkg::EXP_BIAS) begin
				mr = mr << 1;
				er--;
			end
		end
		if (er > spfa_pkg::EXP_BIAS) return {sr, 31'd0} | spfa_pkg::POS_INF;
		return {sr, 8'(er + spfa_pkg::EXP_BIAS), mr[22:0]};
	endfunction

	// directed words: known ones carry their sum, the rest go to the predictor
	vec_t directed[] = '{
		'{spfa_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{spfa_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{spfa_pkg::OP_SUB, 32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h0000_0000},
		'{spfa_pkg::OP_ADD, 32'h7fc0_1234, 32'h3f80_0000, 1'b1, 32'h7fc0_1234},
		'{spfa_pkg::OP_ADD, 32'h7f80_0000, 32'hffc0_0001, 1'b1, 32'hffc0_0001},
		'{spfa_pkg::OP_SUB, 32'h7f80_0000, 32'h7f80_0000, 1'b1, 32'h7fc0_0000},
		'{spfa_pkg::OP_ADD, 32'h7f80_0000, 32'hff80_0000, 1'b1, 32'h7fc0_0000},
		'{spfa_pkg::OP_ADD, 32'hff80_0000, 32'hff80_0000, 1'b1, 32'hff80_0000},
		'{spfa_pkg::OP_ADD, 32'h7f80_0000, 32'h4000_0000, 1'b1, 32'h7f80_0000},
		'{spfa_pkg::OP_SUB, 32'h4000_0000, 32'h7f80_0000, 1'b1, 32'hff80_0000},
		'{spfa_pkg::OP_SUB, 32'h4000_0000, 32'h7fa0_0000, 1'b1, 32'hffa0_0000},
		'{spfa_pkg::OP_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff, 1'b1, 32'h7f80_0000},
		'{spfa_pkg::OP_SUB, 32'hff7f_ffff, 32'h7f7f_ffff, 1'b1, 32'hff80_0000},
		'{spfa_pkg::OP_ADD, 32'h3f80_0000, 32'h3f80_0000, 1'b0, 32'h0},
		'{spfa_pkg::OP_SUB, 32'h3f80_0000, 32'h4000_0000, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0},
		'{spfa_pkg::OP_SUB, 32'h007f_ffff, 32'h0000_0001, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h3f80_0000, 32'h3380_0000, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h3f80_0000, 32'h3380_0001, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h3f80_0000, 32'h3300_0000, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h3fff_ffff, 32'h3f80_0001, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h3f7f_ffff, 32'h3380_0000, 1'b0, 32'h0},
		'{spfa_pkg::OP_SUB, 32'h3f80_0000, 32'h3f7f_ffff, 1'b0, 32'h0},
		'{spfa_pkg::OP_ADD, 32'h0080_0000, 32'h8000_0001, 1'b0, 32'h0},
		'{spfa_pkg::OP_SUB, 32'hffff_fffe, 32'h0000_0000, 1'b0, 32'h0}
	};

	function automatic logic [31:0] rand_float();
		logic [31:0] f;
		f = $urandom;
		case ($urandom_range(0, 9))
			0: f[30:23] = 8'hff;
			1: f[30:23] = 8'h00;
			2: f[30:23] = 8'hfe;
			3: f[30:0] = 31'd0;
			4: f[22:0] = 23'($urandom_range(0, 3));
			default: f[30:23] = 8'($urandom_range(100, 154));
		endcase
		return f;
	endfunction

	task automatic send_word(spfa_pkg::op_t op, logic [31:0] a, logic [31:0] b,
		logic [31:0] sum);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		left_operand <= a;
		right_operand <= b;
		sum_queue.push_back(sum);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(int count);
		spfa_pkg::op_t op;
		logic [31:0]   a, b;
		for (int i = 0; i < count; i++) begin
			op = spfa_pkg::op_t'($urandom_range(0, 1));
			a = rand_float();
			// close exponents half the time so cancellation shows up
			b = ($urandom_range(0, 1)) ? {$urandom_range(0, 1) == 1, a[30:23],
				23'($urandom)} : rand_float();
			send_word(op, a, b, float_sum(op, a, b));
		end
	endtask

	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (sum_queue.size() != 0) @(negedge clk);
	endtask

	// receiver stall
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= hold_rx || ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sum_queue.size() == 0) begin
				$error("unexpected word: sum_bits actual %h", sum_bits);
				errors++;
			end else begin
				if (sum_bits !== sum_queue[0]) begin
					$error("sum_bits mismatch: expected %h actual %h",
						sum_queue[0], sum_bits);
					errors++;
				end
				void'(sum_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		hold_rx = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		left_operand = '0;
		right_operand = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_word(directed[i].op, directed[i].a, directed[i].b,
				directed[i].known ? directed[i].sum :
				float_sum(directed[i].op, directed[i].a, directed[i].b));
		end
		drain_outputs();

		// long output hold-off while words keep arriving
		fork
			begin
				hold_rx = 1'b1;
				repeat (60) @(negedge clk);
				hold_rx = 1'b0;
			end
			run_random(20);
		join
		drain_outputs();

		send_idle_pct = 23;
		recv_idle_pct = 79;
		run_random(450);
		drain_outputs();
		send_idle_pct = 79;
		recv_idle_pct = 23;
		run_random(450);
		drain_outputs();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(500);
		drain_outputs();

		repeat (10) @(negedge clk);
		if (errors == 0 && sum_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
